// File: design/bounded_deque_with_positional_edit_defines.svh
// Assertion macros for the bounded deque with positional edit.
// Used by the top level; relies on clk and rst_n in the including scope.
`ifndef BOUNDED_DEQUE_WITH_POSITIONAL_EDIT_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_POSITIONAL_EDIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define BDQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bdq assertion failed");
`define BDQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bdq assertion failed");
`else
`define BDQ_ASSERT_IMPL(lbl, ante, cons)
`define BDQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: design/bdq_pkg.sv
// Types and codes shared by the bounded deque modules.
// No dependencies.
package bdq_pkg;

  typedef enum logic [2:0] {
    OP_ADD_FRONT  = 3'd0,
    OP_ADD_BACK   = 3'd1,
    OP_DROP_FRONT = 3'd2,
    OP_DROP_BACK  = 3'd3,
    OP_CLEAR      = 3'd4,
    OP_INSERT     = 3'd5,
    OP_REMOVE     = 3'd6,
    OP_LIST       = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    K_VALUE   = 2'd0,
    K_EMPTY   = 2'd1,
    K_INVALID = 2'd2,
    K_FULL    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_UP,
    S_UP_WR,
    S_DN,
    S_DN_WR,
    S_LIST
  } state_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [5:0]         position;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] item_value;
    logic               last;
  } out_item_t;

  // Decoded command handed from the front to the back.
  typedef struct packed {
    op_t                op;
    logic [5:0]         pos;
    logic signed [31:0] value;
  } cmd_t;

endpackage

// File: design/bdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bdq_ram #(
  parameter int W = 32,
  parameter int D = 32
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: design/bdq_front.sv
// Front end: accepts requests, decodes them and holds them in a two-entry queue.
// Depends on bdq_pkg.
module bdq_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  bdq_pkg::in_item_t in_item,
  output logic              cmd_valid,
  input  logic              cmd_take,
  output bdq_pkg::cmd_t     cmd
);
  import bdq_pkg::*;

  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       dec;
  logic       do_push, do_pop;

  // Decode: position zero acts as position one.
  always_comb begin
    dec.op    = op_t'(in_item.action);
    dec.pos   = (in_item.position == 6'd0) ? 6'd1 : in_item.position;
    dec.value = in_item.value;
  end

  assign in_full   = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign do_push   = in_push && !in_full;
  assign do_pop    = cmd_take && cmd_valid;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= dec;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
      if (do_push && !do_pop) cnt_r <= cnt_r + 2'd1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 2'd1;
    end
  end
endmodule

// File: design/bdq_back.sv
// Back end: executes commands on the list memory and drives the result register.
// Depends on bdq_pkg and bdq_ram.
module bdq_back #(
  parameter int DEPTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cmd_valid,
  output logic                         cmd_take,
  input  bdq_pkg::cmd_t                cmd,
  output logic                         out_empty,
  input  logic                         out_pop,
  output bdq_pkg::out_item_t           out_item,
  output logic [$clog2(DEPTH+1)-1:0]   count
);
  import bdq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);

  state_t    state_r, state_nxt;
  cmd_t      cmd_r, cmd_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic      pend_r, pend_nxt;
  logic      last_r, last_nxt;
  out_item_t out_r, out_nxt;
  logic      out_v_r, out_v_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;
  logic          is_full, is_empty, pos_bad, out_free;
  logic          st_v;
  kind_t         st_kind;

  bdq_ram #(.W(32), .D(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign is_full   = (int'(count_r) == DEPTH);
  assign is_empty  = (count_r == '0);
  assign pos_bad   = (int'(cmd_r.pos) >= int'(count_r));
  assign out_free  = !out_v_r || out_pop;
  assign out_empty = !out_v_r;
  assign out_item  = out_r;
  assign count     = count_r;

  // Command sequencer: one step of a shift or one listed value per pass.
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    lo_nxt    = lo_r;
    pend_nxt  = pend_r;
    last_nxt  = last_r;
    out_nxt   = out_r;
    out_v_nxt = out_v_r;
    we        = 1'b0;
    waddr     = idx_r[AW-1:0];
    wdata     = rdata;
    raddr     = idx_r[AW-1:0];
    cmd_take  = 1'b0;
    st_v      = 1'b0;
    st_kind   = K_EMPTY;

    if (out_pop && out_v_r) out_v_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_take  = 1'b1;
          cmd_nxt   = cmd;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd_r.op)
          OP_ADD_FRONT: begin
            if (is_full) begin
              st_v = 1'b1; st_kind = K_FULL;
            end else begin
              idx_nxt = count_r; lo_nxt = '0; state_nxt = S_UP;
            end
          end
          OP_ADD_BACK: begin
            if (is_full) begin
              st_v = 1'b1; st_kind = K_FULL;
            end else begin
              idx_nxt = count_r; lo_nxt = count_r; state_nxt = S_UP;
            end
          end
          OP_DROP_FRONT: begin
            if (is_empty) begin
              st_v = 1'b1;
            end else begin
              idx_nxt = '0; state_nxt = S_DN;
            end
          end
          OP_DROP_BACK: begin
            if (is_empty) begin
              st_v = 1'b1;
            end else begin
              count_nxt = count_r - 1'b1; state_nxt = S_IDLE;
            end
          end
          OP_CLEAR: begin
            if (is_empty) begin
              st_v = 1'b1;
            end else begin
              count_nxt = '0; state_nxt = S_IDLE;
            end
          end
          OP_INSERT: begin
            if (pos_bad) begin
              st_v = 1'b1; st_kind = K_INVALID;
            end else if (is_full) begin
              st_v = 1'b1; st_kind = K_FULL;
            end else begin
              idx_nxt = count_r; lo_nxt = CW'(cmd_r.pos); state_nxt = S_UP;
            end
          end
          OP_REMOVE: begin
            if (pos_bad) begin
              st_v = 1'b1; st_kind = K_INVALID;
            end else begin
              idx_nxt = CW'(cmd_r.pos) - 1'b1; state_nxt = S_DN;
            end
          end
          default: begin
            if (is_empty) begin
              st_v = 1'b1;
            end else begin
              idx_nxt = '0; pend_nxt = 1'b0; state_nxt = S_LIST;
            end
          end
        endcase
        // A status result waits here until the result register is free.
        if (st_v && out_free) begin
          out_nxt.kind       = st_kind;
          out_nxt.item_value = '0;
          out_nxt.last       = 1'b1;
          out_v_nxt          = 1'b1;
          state_nxt          = S_IDLE;
        end
      end
      S_UP: begin
        // Move entries up one place until the gap reaches the target.
        if (idx_r > lo_r) begin
          raddr     = AW'(idx_r - 1'b1);
          state_nxt = S_UP_WR;
        end else begin
          we        = 1'b1;
          waddr     = lo_r[AW-1:0];
          wdata     = cmd_r.value;
          count_nxt = count_r + 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_UP_WR: begin
        we        = 1'b1;
        idx_nxt   = idx_r - 1'b1;
        state_nxt = S_UP;
      end
      S_DN: begin
        // Move entries down one place to close the gap.
        if (CW'(idx_r + 1'b1) < count_r) begin
          raddr     = AW'(idx_r + 1'b1);
          state_nxt = S_DN_WR;
        end else begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DN_WR: begin
        we        = 1'b1;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_DN;
      end
      S_LIST: begin
        if (pend_r) begin
          out_nxt.kind       = K_VALUE;
          out_nxt.item_value = rdata;
          out_nxt.last       = last_r;
          out_v_nxt          = 1'b1;
          pend_nxt           = 1'b0;
          if (last_r) state_nxt = S_IDLE;
        end else if (out_free) begin
          pend_nxt = 1'b1;
          last_nxt = (CW'(idx_r + 1'b1) == count_r);
          idx_nxt  = idx_r + 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      out_v_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      out_v_r <= out_v_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Payload and index registers.
  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    idx_r  <= idx_nxt;
    lo_r   <= lo_nxt;
    last_r <= last_nxt;
    out_r  <= out_nxt;
  end
endmodule

// File: design/bounded_deque_with_positional_edit.sv
// Bounded deque with positional insert and remove over a DEPTH-entry RAM.
// Commands run one at a time. Status results, drop back and clear finish in the execute
// state; add back then writes in S_UP; add front, insert, drop front and remove spend a
// read state and a write state per moved entry. A list paces its values by the registered RAM
// read and the result register. Reset (synchronous, rst_n low) empties the list, the command
// queue and the result register; the RAM is not cleared.
module bounded_deque_with_positional_edit #(
  parameter int DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  bdq_pkg::in_item_t   in_item,
  output logic                out_empty,
  input  logic                out_pop,
  output bdq_pkg::out_item_t  out_item
);
  import bdq_pkg::*;
`include "bounded_deque_with_positional_edit_defines.svh"

  logic cmd_valid, cmd_take;
  cmd_t cmd;
  logic [$clog2(DEPTH+1)-1:0] count;

  bdq_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
  );

  bdq_back #(.DEPTH(DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item), .count(count)
  );

  // The list never holds more than DEPTH values.
  `BDQ_ASSERT_IMPL(a_count_bound, 1'b1, int'(count) <= DEPTH)
  // Status results carry a zero value and always close their request.
  `BDQ_ASSERT_IMPL(a_status_shape, !out_empty && out_item.kind != K_VALUE,
                   out_item.item_value == 0 && out_item.last)
  // A result that is not taken is still there in the next cycle.
  `BDQ_ASSERT_NEXT(a_result_held, !out_empty && !out_pop, !out_empty)
endmodule
